// ===== hdl/set_assoc_lru_cache_with_prefetch_top_assert.svh =====
// assertion macros for the cache top
`ifndef SET_ASSOC_LRU_CACHE_WITH_PREFETCH_TOP_ASSERT_SVH
`define SET_ASSOC_LRU_CACHE_WITH_PREFETCH_TOP_ASSERT_SVH

// property that must hold in the cycle after a condition
`define SALC_ASSERT_NEXT(lbl, clk, rst_n, cond, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error(msg);

// property that must hold in the same cycle as a condition
`define SALC_ASSERT_NOW(lbl, clk, rst_n, cond, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error(msg);

`endif

// ===== hdl/salc_pkg.sv =====
`default_nettype none
package salc_pkg;

    // register indexes
    localparam logic [1:0] REG_WAYS_LOG2 = 2'd0;
    localparam logic [1:0] REG_STORE_NA  = 2'd1;
    localparam logic [1:0] REG_PF_MODE   = 2'd2;

    // prefetch modes, the last one acts as none
    localparam logic [1:0] PF_NONE   = 2'd0;
    localparam logic [1:0] PF_ALL    = 2'd1;
    localparam logic [1:0] PF_ALLOC  = 2'd2;
    localparam logic [1:0] PF_UNUSED = 2'd3;

    typedef struct packed {
        logic [31:0] access_address;
        logic        is_store;
    } t_in_word;

    typedef struct packed {
        logic        hit;
        logic        filled;
        logic        prefetch_filled;
        logic [31:0] hit_total;
    } t_out_word;

    // back-end sequencer states
    typedef enum logic [2:0] {
        ST_CLR,
        ST_IDLE,
        ST_RD,
        ST_SCAN,
        ST_DECIDE,
        ST_WRITE,
        ST_DONE
    } t_state;

endpackage
`default_nettype wire

// ===== hdl/set_assoc_lru_cache_with_prefetch_top.sv =====
// the front part queues up to two words while the back part scans the ways one by one;
// a prefetch adds a second scan of the next line; a hit ends a scan early
// the single tag memory port is read once per way
// reset: synchronous active low, clears counters and registers, then a pass over all
// NUM_LINES lines clears the tag memory; the receiver cannot stall, a two-word queue
`default_nettype none
`include "set_assoc_lru_cache_with_prefetch_top_assert.svh"
module set_assoc_lru_cache_with_prefetch_top #(
    parameter int NUM_LINES  = 512,
    parameter int LINE_BYTES = 32,
    parameter int STAMP_BITS = 32
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  start,
    output logic                 busy,
    input  salc_pkg::t_in_word   i_word,
    input  wire                  i_cfg_we,
    input  wire [1:0]            i_cfg_idx,
    input  wire [3:0]            i_cfg_data,
    output logic                 o_strobe,
    output salc_pkg::t_out_word  o_word
);
    logic [3:0] r_ways_log2;
    logic       r_store_na;
    logic [1:0] r_pf_mode;
    logic       w_pop, w_valid, w_full;
    salc_pkg::t_in_word w_q;

    assign busy = w_full;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ways_log2 <= 4'd1;
            r_store_na  <= 1'b0;
            r_pf_mode   <= salc_pkg::PF_NONE;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                salc_pkg::REG_WAYS_LOG2: r_ways_log2 <= i_cfg_data;
                salc_pkg::REG_STORE_NA:  r_store_na  <= i_cfg_data[0];
                salc_pkg::REG_PF_MODE:   r_pf_mode   <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    salc_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(start && !busy), .i_word(i_word),
        .i_pop(w_pop), .o_full(w_full), .o_valid(w_valid), .o_word(w_q)
    );

    salc_back #(.NUM_LINES(NUM_LINES), .LINE_BYTES(LINE_BYTES), .STAMP_BITS(STAMP_BITS))
    u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(w_valid), .i_word(w_q), .o_pop(w_pop),
        .i_ways_log2(r_ways_log2), .i_store_na(r_store_na), .i_pf_mode(r_pf_mode),
        .o_strobe(o_strobe), .o_word(o_word)
    );

    `SALC_ASSERT_NOW(a_pop_has_word, i_clk, i_rst_n, w_pop, w_valid, "pop from empty queue")
    `SALC_ASSERT_NEXT(a_strobe_pulse, i_clk, i_rst_n, o_strobe, !o_strobe, "strobe held two cycles")
endmodule
`default_nettype wire

// ===== hdl/salc_front.sv =====
`default_nettype none
// front part: accepts words, holds a two-entry queue
module salc_front (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_push,
    input  salc_pkg::t_in_word   i_word,
    input  wire                  i_pop,
    output logic                 o_full,
    output logic                 o_valid,
    output salc_pkg::t_in_word   o_word
);
    salc_pkg::t_in_word r_q [2];
    logic [1:0] r_cnt;
    logic       r_rd;
    logic       r_wr;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_word  = r_q[r_rd];

    // queue pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_rd  <= 1'b0;
            r_wr  <= 1'b0;
        end else begin
            if (i_push) r_wr <= ~r_wr;
            if (i_pop)  r_rd <= ~r_rd;
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (i_push) r_q[r_wr] <= i_word;
    end
endmodule
`default_nettype wire

// ===== hdl/salc_back.sv =====
`default_nettype none
// back part: sequential way scan over the tag memory
module salc_back #(
    parameter int NUM_LINES  = 512,
    parameter int LINE_BYTES = 32,
    parameter int STAMP_BITS = 32
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_valid,
    input  salc_pkg::t_in_word   i_word,
    output logic                 o_pop,
    input  wire [3:0]            i_ways_log2,
    input  wire                  i_store_na,
    input  wire [1:0]            i_pf_mode,
    output logic                 o_strobe,
    output salc_pkg::t_out_word  o_word
);
    localparam int LL = $clog2(NUM_LINES);
    localparam int OFF = $clog2(LINE_BYTES);
    localparam int LA = 32 - OFF;
    localparam int TW = LA;
    localparam int ENT = 1 + TW + STAMP_BITS;

    // tag memory: valid bit, tag and stamp per line, cleared by a pass after reset
    logic [ENT-1:0] mem [NUM_LINES];
    logic [ENT-1:0] r_rdata;
    logic [LL-1:0]  r_clr;

    salc_pkg::t_state r_st, n_st;
    logic [LA-1:0]  r_line;
    logic           r_store, r_pf_phase;
    logic [LL:0]    r_k;
    logic [LL-1:0]  r_idx;
    logic           r_hit, r_have_inv, r_have_best;
    logic [LL-1:0]  r_hit_idx, r_inv_idx, r_best_idx;
    logic [STAMP_BITS-1:0] r_best;
    logic           r_d_hit, r_d_fill, r_pf_fill;
    logic [31:0]    r_count, r_hits;
    logic [31:0]    r_addr;

    logic [3:0]    w_eff;
    logic [LL-1:0] w_set_mask;
    logic [LL:0]   w_ways;
    logic [LL-1:0] w_set;
    logic [LA-1:0] w_tag;
    logic [LL-1:0] w_k_idx;
    logic          w_alloc;
    logic [LL-1:0] w_vict;
    logic          w_rv;
    logic          w_match;

    assign w_eff      = (i_ways_log2 > 4'(LL)) ? 4'(LL) : i_ways_log2;
    assign w_ways     = (LL+1)'(1) << w_eff;
    assign w_set_mask = ~(LL'({LL{1'b1}} << (LL - int'(w_eff))));
    assign w_set      = r_line[LL-1:0] & w_set_mask;
    assign w_tag      = r_line >> (LL - int'(w_eff));
    assign w_k_idx    = w_set + LL'(r_k[LL-1:0] << (LL - int'(w_eff)));
    assign w_alloc    = r_pf_phase | ~(r_store & i_store_na);
    assign w_vict     = r_have_inv ? r_inv_idx : r_best_idx;
    assign w_rv       = r_rdata[ENT-1];
    assign w_match    = w_rv & (r_rdata[TW+STAMP_BITS-1:STAMP_BITS] == w_tag);

    // next state and control
    always_comb begin
        n_st  = r_st;
        o_pop = 1'b0;
        case (r_st)
            salc_pkg::ST_CLR:    if (r_clr == {LL{1'b1}}) n_st = salc_pkg::ST_IDLE;
            salc_pkg::ST_IDLE:   if (i_valid) begin n_st = salc_pkg::ST_RD; o_pop = 1'b1; end
            salc_pkg::ST_RD:     n_st = salc_pkg::ST_SCAN;
            salc_pkg::ST_SCAN: begin
                if (w_match || r_k + 1'b1 >= w_ways) n_st = salc_pkg::ST_DECIDE;
                else n_st = salc_pkg::ST_RD;
            end
            salc_pkg::ST_DECIDE: n_st = salc_pkg::ST_WRITE;
            salc_pkg::ST_WRITE: begin
                if (!r_pf_phase && (i_pf_mode == salc_pkg::PF_ALL ||
                    (i_pf_mode == salc_pkg::PF_ALLOC && !r_hit && w_alloc)))
                    n_st = salc_pkg::ST_RD;
                else n_st = salc_pkg::ST_DONE;
            end
            salc_pkg::ST_DONE:   n_st = salc_pkg::ST_IDLE;
            default:             n_st = salc_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_st <= salc_pkg::ST_CLR;
        else          r_st <= n_st;
    end

    // memory clear, read and write
    always_ff @(posedge i_clk) begin
        if (r_st == salc_pkg::ST_CLR)
            mem[r_clr] <= '0;
        if (r_st == salc_pkg::ST_RD) begin
            r_rdata <= mem[w_k_idx];
            r_idx   <= w_k_idx;
        end
        if (r_st == salc_pkg::ST_WRITE && (r_hit || w_alloc))
            mem[r_hit ? r_hit_idx : w_vict] <= {1'b1, w_tag, STAMP_BITS'(r_count)};
    end

    // scan bookkeeping and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr    <= '0;
            r_count  <= '0;
            r_hits   <= '0;
            o_strobe <= 1'b0;
        end else begin
            o_strobe <= (r_st == salc_pkg::ST_DONE);
            case (r_st)
                salc_pkg::ST_CLR: r_clr <= r_clr + 1'b1;
                salc_pkg::ST_IDLE: if (i_valid) begin
                    r_addr      <= i_word.access_address;
                    r_line      <= i_word.access_address[31:OFF];
                    r_store     <= i_word.is_store;
                    r_pf_phase  <= 1'b0;
                    r_k <= '0; r_hit <= 1'b0; r_have_inv <= 1'b0; r_have_best <= 1'b0;
                    r_pf_fill <= 1'b0; r_d_fill <= 1'b0; r_d_hit <= 1'b0;
                end
                salc_pkg::ST_RD: ;
                salc_pkg::ST_SCAN: begin
                    r_k <= r_k + 1'b1;
                    if (w_match) begin r_hit <= 1'b1; r_hit_idx <= r_idx; end
                    if (!w_rv && !r_have_inv) begin r_have_inv <= 1'b1; r_inv_idx <= r_idx; end
                    if (w_rv && (!r_have_best || r_rdata[STAMP_BITS-1:0] < r_best)) begin
                        r_have_best <= 1'b1;
                        r_best      <= r_rdata[STAMP_BITS-1:0];
                        r_best_idx  <= r_idx;
                    end
                end
                salc_pkg::ST_DECIDE: ;
                salc_pkg::ST_WRITE: begin
                    if (!r_pf_phase) begin
                        r_d_hit  <= r_hit;
                        r_d_fill <= !r_hit && w_alloc;
                        if (r_hit && r_hits != '1) r_hits <= r_hits + 1'b1;
                    end else r_pf_fill <= !r_hit;
                    r_pf_phase <= 1'b1;
                    r_line <= r_addr[31:OFF] + 1'b1;
                    r_k <= '0; r_hit <= 1'b0; r_have_inv <= 1'b0; r_have_best <= 1'b0;
                end
                salc_pkg::ST_DONE: begin
                    r_count  <= r_count + 1'b1;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        o_word.hit             <= r_d_hit;
        o_word.filled          <= r_d_fill;
        o_word.prefetch_filled <= r_pf_fill;
        o_word.hit_total       <= r_hits;
    end
endmodule
`default_nettype wire

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps
`default_nettype none
module testbench;

    localparam int LINES    = 512;
    localparam int OFF_BITS = 5;
    localparam longint CYCLE_LIMIT = 20000000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    wire         busy;
    salc_pkg::t_in_word    i_word = '0;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_idx = '0;
    logic [3:0]  i_cfg_data = '0;
    wire         o_strobe;
    salc_pkg::t_out_word   o_word;

    set_assoc_lru_cache_with_prefetch_top uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_word(i_word), .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data), .o_strobe(o_strobe), .o_word(o_word)
    );

    always #10 i_clk = ~i_clk;

    // predictor state
    logic [3:0]  mdl_ways_log2;
    logic        mdl_store_na;
    logic [1:0]  mdl_pf_mode;
    logic        tag_valid [LINES];
    logic [26:0] tag_mem [LINES];
    logic [31:0] stamp_mem [LINES];
    logic [31:0] access_cnt;
    logic [31:0] hit_cnt;

    salc_pkg::t_in_word  pending_words[$];
    salc_pkg::t_out_word expected_words[$];
    int        idle_pct = 0;
    int        n_errors = 0;
    int        n_checked = 0;
    int        n_sent = 0;
    int        n_hits = 0;
    int        n_pf_fills = 0;
    longint    cycle_cnt = 0;

    // lookup of one line address in the tag store; returns 1 when a line is allocated
    function automatic bit tag_lookup(input logic [26:0] line_addr, input bit may_alloc,
                                      input logic [31:0] stamp, output bit was_hit);
        int w, sets_log2, sets, ways, set_idx, idx, victim, inv_idx;
        logic [26:0] tag;
        bit have_inv;
        logic [31:0] best;
        w = (mdl_ways_log2 > 9) ? 9 : int'(mdl_ways_log2);
        sets_log2 = 9 - w;
        sets = 1 << sets_log2;
        ways = 1 << w;
        set_idx = int'(line_addr & (sets - 1));
        tag = line_addr >> sets_log2;
        have_inv = 0;
        inv_idx = 0;
        was_hit = 0;
        for (int k = 0; k < ways; k++) begin
            idx = set_idx + k * sets;
            if (tag_valid[idx] && tag_mem[idx] == tag) begin
                stamp_mem[idx] = stamp;
                was_hit = 1;
                return 0;
            end
            if (!tag_valid[idx] && !have_inv) begin
                have_inv = 1;
                inv_idx = idx;
            end
        end
        if (!may_alloc) return 0;
        if (have_inv) begin
            victim = inv_idx;
        end else begin
            victim = set_idx;
            best = stamp_mem[set_idx];
            for (int k = 1; k < ways; k++) begin
                idx = set_idx + k * sets;
                if (stamp_mem[idx] < best) begin
                    best = stamp_mem[idx];
                    victim = idx;
                end
            end
        end
        tag_valid[victim] = 1;
        tag_mem[victim] = tag;
        stamp_mem[victim] = stamp;
        return 1;
    endfunction

    // expected result of one access
    function automatic salc_pkg::t_out_word predict_access(input salc_pkg::t_in_word wd);
        salc_pkg::t_out_word r;
        bit h, f, pf, ph;
        logic [31:0] nxt;
        f = tag_lookup(wd.access_address[31:OFF_BITS], !(wd.is_store && mdl_store_na),
                       access_cnt, h);
        if (h && hit_cnt != 32'hFFFF_FFFF) hit_cnt++;
        pf = 0;
        if (mdl_pf_mode == salc_pkg::PF_ALL || (mdl_pf_mode == salc_pkg::PF_ALLOC && f)) begin
            nxt = wd.access_address + 32'd32;
            pf = tag_lookup(nxt[31:OFF_BITS], 1'b1, access_cnt, ph);
        end
        access_cnt++;
        r.hit = h;
        r.filled = f;
        r.prefetch_filled = pf;
        r.hit_total = hit_cnt;
        return r;
    endfunction

    // driver: one word per accepted start
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy) begin
                expected_words.insert(expected_words.size(), predict_access(i_word));
                n_sent++;
                void'(pending_words.pop_front());
            end
            if (start && busy) begin
                start <= 1'b1;
            end else if (pending_words.size() > 0 && $urandom_range(99) >= idle_pct) begin
                start <= 1'b1;
                i_word <= pending_words[0];
            end else begin
                start <= 1'b0;
            end
        end
    end

    // monitor: compare each result word with the oldest expectation
    always @(posedge i_clk) begin
        salc_pkg::t_out_word exp_w;
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("TB_ERROR");
            $finish;
        end
        if (i_rst_n && o_strobe) begin
            if (expected_words.size() == 0) begin
                n_errors++;
                if (n_errors <= 10) $display("unexpected word %h", o_word);
            end else begin
                exp_w = expected_words.pop_front();
                n_checked++;
                if (exp_w.hit) n_hits++;
                if (exp_w.prefetch_filled) n_pf_fills++;
                if (o_word !== exp_w) begin
                    n_errors++;
                    if (n_errors <= 10) begin
                        $display("mismatch %0d: exp hit=%b fill=%b pf=%b tot=%0d",
                                 n_checked, exp_w.hit, exp_w.filled,
                                 exp_w.prefetch_filled, exp_w.hit_total);
                        $display("    got hit=%b fill=%b pf=%b tot=%0d",
                                 o_word.hit, o_word.filled,
                                 o_word.prefetch_filled, o_word.hit_total);
                    end
                end
            end
        end
    end

    task automatic wait_drained();
        while (pending_words.size() != 0 || start || expected_words.size() != 0)
            @(posedge i_clk);
        repeat (3 * 512 * 2 + 40) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [3:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == salc_pkg::REG_WAYS_LOG2) mdl_ways_log2 = val;
        else if (idx == salc_pkg::REG_STORE_NA) mdl_store_na = val[0];
        else mdl_pf_mode = val[1:0];
    endtask

    function automatic salc_pkg::t_in_word mk_word(input logic [31:0] a, input logic s);
        salc_pkg::t_in_word w;
        w.access_address = a;
        w.is_store = s;
        return w;
    endfunction

    // append one word to the pending list
    function automatic void add_word(input logic [31:0] a, input logic s);
        pending_words.insert(pending_words.size(), mk_word(a, s));
    endfunction

    // random traffic: mostly a small working set so sets fill and evict
    task automatic add_random(input int n, input int ways_sel);
        logic [31:0] base;
        logic [31:0] a;
        int span;
        base = $urandom;
        span = (ways_sel >= 6) ? 2048 : 96;
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(9))
                0:       a = $urandom;
                1:       a = 32'hFFFF_FFE0 | $urandom_range(31);
                default: a = base + ($urandom_range(span - 1) << OFF_BITS)
                             + ($urandom_range(3) << 14) * 512 + $urandom_range(31);
            endcase
            add_word(a, $urandom_range(1));
        end
    endtask

    initial begin
        logic [3:0] ways_cfg [8] = '{4'd1, 4'd0, 4'd9, 4'd15, 4'd2, 4'd3, 4'd5, 4'd1};
        logic [1:0] pf_cfg [8]   = '{salc_pkg::PF_NONE, salc_pkg::PF_ALL, salc_pkg::PF_ALLOC,
                                     salc_pkg::PF_ALL, salc_pkg::PF_UNUSED,
                                     salc_pkg::PF_ALLOC, salc_pkg::PF_ALL,
                                     salc_pkg::PF_NONE};
        int         idle_cfg [8] = '{0, 79, 0, 25, 79, 0, 25, 79};
        mdl_ways_log2 = 4'd1;
        mdl_store_na = 1'b0;
        mdl_pf_mode = salc_pkg::PF_NONE;
        access_cnt = '0;
        hit_cnt = '0;
        for (int i = 0; i < LINES; i++) begin
            tag_valid[i] = 0;
            tag_mem[i] = '0;
            stamp_mem[i] = '0;
        end
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes, hits, evictions, address wrap, store no allocate
        write_reg(salc_pkg::REG_PF_MODE, {2'b00, salc_pkg::PF_ALL});
        add_word(32'h0000_0000, 1'b0);
        add_word(32'h0000_001F, 1'b0);
        add_word(32'hFFFF_FFFF, 1'b1);
        add_word(32'hFFFF_FFE0, 1'b0);
        add_word(32'h0000_0000, 1'b1);
        add_word(32'h0000_4000, 1'b0);
        add_word(32'h0000_8000, 1'b0);
        add_word(32'h0000_0000, 1'b0);
        add_word(32'hAAAA_AAAA, 1'b0);
        add_word(32'h5555_5555, 1'b1);
        wait_drained();
        write_reg(salc_pkg::REG_STORE_NA, 4'd1);
        write_reg(salc_pkg::REG_PF_MODE, {2'b00, salc_pkg::PF_ALLOC});
        add_word(32'h1234_5600, 1'b1);
        add_word(32'h1234_5600, 1'b0);
        add_word(32'h1234_5620, 1'b1);
        add_word(32'h7FFF_FFE0, 1'b1);
        wait_drained();
        write_reg(salc_pkg::REG_PF_MODE, {2'b00, salc_pkg::PF_ALL});
        add_word(32'h0BAD_0000, 1'b1);
        add_word(32'h0BAD_0020, 1'b0);
        wait_drained();

        // random phases across layouts and modes
        for (int p = 0; p < 8; p++) begin
            write_reg(salc_pkg::REG_WAYS_LOG2, ways_cfg[p]);
            write_reg(salc_pkg::REG_STORE_NA, {3'b000, p[0]});
            write_reg(salc_pkg::REG_PF_MODE, {2'b00, pf_cfg[p]});
            idle_pct = idle_cfg[p];
            add_random((ways_cfg[p] >= 5) ? 60 : 220, ways_cfg[p]);
            wait_drained();
        end

        $display("covered %0d accesses over 8 layouts and all prefetch modes", n_sent);
        $display("checked %0d results, %0d hits, %0d prefetch fills",
                 n_checked, n_hits, n_pf_fills);
        if (n_errors == 0 && expected_words.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("%0d mismatches", n_errors);
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
`default_nettype wire
